/* hw/rtl/lsh_pkg.sv */
// Shared types, constants and the per-channel sharpening function.
`default_nettype none
package lsh_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int GAIN_W     = 8;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_SLOTS  = 3;
    localparam int CNT_W      = $clog2(NUM_SLOTS + 1);

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(480);
    localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(16);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_GAIN   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last_of_run;
        logic       frame_done;
    } t_pix_out;

    // centre + gain*(4*centre - neighbours)/16, floored at 0 and saturated at 255
    function automatic logic [7:0] sharpen_ch(
        input logic [7:0]        up,
        input logic [7:0]        dn,
        input logic [7:0]        lf,
        input logic [7:0]        ctr,
        input logic [7:0]        rt,
        input logic [GAIN_W-1:0] gain
    );
        logic signed [10:0] s;
        logic signed [19:0] p;
        logic signed [19:0] t;
        logic [7:0]         v;
        s = $signed({1'b0, ctr, 2'b00}) - $signed({3'b000, up}) - $signed({3'b000, dn})
            - $signed({3'b000, lf}) - $signed({3'b000, rt});
        p = s * $signed({1'b0, gain});
        t = $signed({8'b0, ctr, 4'b0000}) + p;
        if (t < 0) begin
            v = 8'd0;
        end else if (t[19:12] != 8'd0) begin
            v = 8'd255;
        end else begin
            v = t[11:4];
        end
        return v;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/lsh_in_if.sv */
// Pixel input channel: valid/ready handshake with one RGB pixel per beat.
`default_nettype none
interface lsh_in_if;
    logic            valid;
    logic            ready;
    lsh_pkg::t_pix_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/lsh_out_if.sv */
// Result output channel: valid/ready handshake with one result pixel per beat.
`default_nettype none
interface lsh_out_if;
    logic              valid;
    logic              ready;
    lsh_pkg::t_pix_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/laplacian_sharpen_3x3_rgb_top.sv */
// An accepted pixel is held in the stage register, then loaded into the result slots once they drain.
// Results trail the input by one row; the last row's own pixels follow at once.
// Throughput: one pixel per cycle while o_res is ready; a pixel causing k result beats (last column,
// last row) holds the input until its beats drain, set by the single output beat per cycle.
// Reset (i_rst_n low, synchronous): counters, pipeline and registers to defaults;
// the two line memories are not cleared, unwritten entries only feed border pixels.
`default_nettype none
module laplacian_sharpen_3x3_rgb_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lsh_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lsh_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    lsh_in_if.sink                            i_pix,
    lsh_out_if.source                         o_res
);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [lsh_pkg::WIDTH_W-1:0]  r_width;
    logic [lsh_pkg::HEIGHT_W-1:0] r_height;
    logic [lsh_pkg::GAIN_W-1:0]   r_gain;
    logic                         w_geom_wr;

    // Effective geometry: zero acts as one, oversize clamps to MAX_WIDTH and MAX_HEIGHT.
    logic [lsh_pkg::WIDTH_W-1:0]  w_width_eff;
    logic [lsh_pkg::HEIGHT_W-1:0] w_height_eff;

    // ---------------------------------------------------------------------
    // Frame position of the next pixel to arrive
    // ---------------------------------------------------------------------
    logic [lsh_pkg::COL_W-1:0] r_col;
    logic [lsh_pkg::ROW_W-1:0] r_row;
    logic                      w_last_col;
    logic                      w_last_row;

    // ---------------------------------------------------------------------
    // Line memories and the stage that holds one accepted pixel
    // ---------------------------------------------------------------------
    lsh_pkg::t_rgb r_upper_line  [lsh_pkg::MAX_WIDTH];
    lsh_pkg::t_rgb r_middle_line [lsh_pkg::MAX_WIDTH];

    logic                      r_s1_valid;
    lsh_pkg::t_rgb             r_px;
    lsh_pkg::t_rgb             r_up_rd;
    lsh_pkg::t_rgb             r_mid_rd;
    logic                      r_byp;
    lsh_pkg::t_rgb             r_byp_up;
    lsh_pkg::t_rgb             r_byp_mid;
    logic [lsh_pkg::COL_W-1:0] r_wa;
    logic                      r_e1;
    logic                      r_e2;
    logic                      r_e3;
    logic                      r_interior;
    logic                      r_lc;

    lsh_pkg::t_rgb r_win [6];

    // ---------------------------------------------------------------------
    // Result slots, head in slot 0
    // ---------------------------------------------------------------------
    lsh_pkg::t_pix_out           r_slot [lsh_pkg::NUM_SLOTS];
    logic [lsh_pkg::CNT_W-1:0]   r_cnt;
    lsh_pkg::t_pix_out           n_slot [lsh_pkg::NUM_SLOTS];
    lsh_pkg::t_pix_out           w_cand [lsh_pkg::NUM_SLOTS];
    logic [lsh_pkg::CNT_W-1:0]   w_n;

    logic          w_in_acc;
    logic          w_pop;
    logic          w_fire;
    logic          w_hit;
    lsh_pkg::t_rgb w_up;
    lsh_pkg::t_rgb w_mid;
    lsh_pkg::t_rgb w_res1;

    // ---------------------------------------------------------------------
    // Handshakes: the held pixel moves into the slots once they drain
    // ---------------------------------------------------------------------
    assign w_pop     = o_res.valid && o_res.ready;
    assign w_fire    = r_s1_valid &&
                       ((r_cnt == '0) || ((r_cnt == lsh_pkg::CNT_W'(1)) && w_pop));
    assign i_pix.ready = !r_s1_valid || w_fire;
    assign w_in_acc  = i_pix.valid && i_pix.ready;
    assign o_res.valid = (r_cnt != '0);
    assign o_res.data  = r_slot[0];

    assign w_geom_wr = i_cfg_we &&
                       ((i_cfg_idx == lsh_pkg::CFG_WIDTH) || (i_cfg_idx == lsh_pkg::CFG_HEIGHT));

    always_comb begin
        if (r_width == '0) begin
            w_width_eff = lsh_pkg::WIDTH_W'(1);
        end else if (r_width > lsh_pkg::WIDTH_W'(lsh_pkg::MAX_WIDTH)) begin
            w_width_eff = lsh_pkg::WIDTH_W'(lsh_pkg::MAX_WIDTH);
        end else begin
            w_width_eff = r_width;
        end
        if (r_height == '0) begin
            w_height_eff = lsh_pkg::HEIGHT_W'(1);
        end else if (r_height > lsh_pkg::HEIGHT_W'(lsh_pkg::MAX_HEIGHT)) begin
            w_height_eff = lsh_pkg::HEIGHT_W'(lsh_pkg::MAX_HEIGHT);
        end else begin
            w_height_eff = r_height;
        end
    end

    assign w_last_col = ({1'b0, r_col} >= (w_width_eff - lsh_pkg::WIDTH_W'(1)));
    assign w_last_row = ({1'b0, r_row} >= (w_height_eff - lsh_pkg::HEIGHT_W'(1)));

    // Same column written and read at one edge only for single-pixel rows: forward.
    assign w_hit = w_in_acc && w_fire && (r_wa == r_col);

    assign w_up  = r_byp ? r_byp_up  : r_up_rd;
    assign w_mid = r_byp ? r_byp_mid : r_mid_rd;

    // ---------------------------------------------------------------------
    // Configuration and position counters
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= lsh_pkg::WIDTH_RST;
            r_height <= lsh_pkg::HEIGHT_RST;
            r_gain   <= lsh_pkg::GAIN_RST;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lsh_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[lsh_pkg::WIDTH_W-1:0];
                    lsh_pkg::CFG_HEIGHT: r_height <= i_cfg_data[lsh_pkg::HEIGHT_W-1:0];
                    lsh_pkg::CFG_GAIN:   r_gain   <= i_cfg_data[lsh_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end
            // restart the frame on a geometry write
            if (w_geom_wr) begin
                r_col <= '0;
                r_row <= '0;
            end else if (w_in_acc) begin
                if (w_last_col) begin
                    r_col <= '0;
                    r_row <= w_last_row ? '0 : r_row + lsh_pkg::ROW_W'(1);
                end else begin
                    r_col <= r_col + lsh_pkg::COL_W'(1);
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Line memories: write on fire, registered read on accept
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_upper_line[r_wa]  <= w_mid;
            r_middle_line[r_wa] <= r_px;
        end
        if (w_in_acc) begin
            r_up_rd  <= r_upper_line[r_col];
            r_mid_rd <= r_middle_line[r_col];
        end
    end

    // ---------------------------------------------------------------------
    // Held pixel: payload and which results it will cause
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_px       <= '{red: i_pix.data.red_in, green: i_pix.data.green_in,
                            blue: i_pix.data.blue_in};
            r_byp      <= w_hit;
            r_byp_up   <= w_mid;
            r_byp_mid  <= r_px;
            r_wa       <= r_col;
            // output (row-1, col-1), emitted when both are at least 1
            r_e1       <= (r_row != '0) && (r_col != '0);
            // right border pixel of the previous row
            r_e2       <= (r_row != '0) && w_last_col;
            // last row passes its own pixel through
            r_e3       <= w_last_row;
            r_interior <= (r_row >= lsh_pkg::ROW_W'(2)) && (r_col >= lsh_pkg::COL_W'(2));
            r_lc       <= w_last_col;
        end
    end

    // ---------------------------------------------------------------------
    // 3x3 window: [0..2] = up/mid/new of the previous column, [3..5] the one before
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (w_fire) begin
            r_win[3] <= r_win[0];
            r_win[4] <= r_win[1];
            r_win[5] <= r_win[2];
            r_win[0] <= w_up;
            r_win[1] <= w_mid;
            r_win[2] <= r_px;
        end
    end

    // ---------------------------------------------------------------------
    // Sharpen the centre of the window, three channels side by side
    // ---------------------------------------------------------------------
    always_comb begin
        if (r_interior) begin
            w_res1.red   = lsh_pkg::sharpen_ch(r_win[0].red, r_win[2].red, r_win[4].red,
                                               r_win[1].red, w_mid.red, r_gain);
            w_res1.green = lsh_pkg::sharpen_ch(r_win[0].green, r_win[2].green,
                                               r_win[4].green, r_win[1].green,
                                               w_mid.green, r_gain);
            w_res1.blue  = lsh_pkg::sharpen_ch(r_win[0].blue, r_win[2].blue, r_win[4].blue,
                                               r_win[1].blue, w_mid.blue, r_gain);
        end else begin
            w_res1 = r_win[1];
        end
    end

    // ---------------------------------------------------------------------
    // Candidate results, packed to the front of the slots
    // ---------------------------------------------------------------------
    always_comb begin
        w_cand[0] = '{red_out: w_res1.red, green_out: w_res1.green, blue_out: w_res1.blue,
                      last_of_run: !r_e2 && !r_e3, frame_done: 1'b0};
        w_cand[1] = '{red_out: w_mid.red, green_out: w_mid.green, blue_out: w_mid.blue,
                      last_of_run: !r_e3, frame_done: 1'b0};
        w_cand[2] = '{red_out: r_px.red, green_out: r_px.green, blue_out: r_px.blue,
                      last_of_run: 1'b1, frame_done: r_lc};
        w_n = lsh_pkg::CNT_W'(r_e1) + lsh_pkg::CNT_W'(r_e2) + lsh_pkg::CNT_W'(r_e3);
        n_slot[0] = r_e1 ? w_cand[0] : (r_e2 ? w_cand[1] : w_cand[2]);
        n_slot[1] = (r_e1 && r_e2) ? w_cand[1] : w_cand[2];
        n_slot[2] = w_cand[2];
    end

    // ---------------------------------------------------------------------
    // Result slots: load on fire, otherwise advance on each output beat
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_fire) begin
            r_cnt <= w_n;
        end else if (w_pop) begin
            r_cnt <= r_cnt - lsh_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            for (int i = 0; i < lsh_pkg::NUM_SLOTS; i++) begin
                r_slot[i] <= n_slot[i];
            end
        end else if (w_pop) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

`ifndef SYNTHESIS
    // end of frame is always the closing beat of its pixel's run
    a_frame_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.frame_done) |-> o_res.data.last_of_run)
        else $error("frame_done without last_of_run");

    // geometry write restarts the frame position
    a_geom_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_geom_wr |=> (r_col == '0) && (r_row == '0))
        else $error("position not cleared by geometry write");

    // a waiting head beat holds until taken
    a_head_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> $stable(r_slot[0]) && (r_cnt != '0))
        else $error("head beat changed while stalled");
`endif

endmodule
`default_nettype wire

/* bench/tb_laplacian_sharpen_3x3_rgb_top.sv */
// Self-checking bench for the 3x3 Laplacian sharpener: random pixel stream, beat-by-beat result check.
module tb_laplacian_sharpen_3x3_rgb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lsh_pkg::*;

    // Idle cycles required before a register write: a margin that also covers pixels
    // that leave no result behind (first rows of a frame).
    localparam int QUIET_CYCLES  = 4;
    localparam int DRAIN_CYCLES  = 16;
    localparam int RANDOM_PIXELS = 140;
    localparam int WIDE_PIXELS   = 24;
    localparam int MAX_REPORTS   = 40;

    typedef enum logic {OP_PIXEL, OP_WRITE} stim_kind_e;

    typedef struct {
        stim_kind_e            kind;
        t_pix_in               px;
        t_cfg_idx              reg_idx;
        logic [CFG_DATA_W-1:0] value;
    } stim_op_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lsh_in_if  pix_ch ();
    lsh_out_if res_ch ();

    laplacian_sharpen_3x3_rgb_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_ch),
        .o_res      (res_ch)
    );

    // Shadow copy of the sharpener: line stores, 3x3 window columns, raster position
    // and the three registers.
    t_rgb                upper_row  [MAX_WIDTH];
    t_rgb                middle_row [MAX_WIDTH];
    t_rgb                win        [6];
    int unsigned         col_pos;
    int unsigned         row_pos;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [GAIN_W-1:0]   gain_reg;

    t_pix_out    expected_beats [$];
    stim_op_t    pending_ops [$];
    int unsigned mismatch_cnt;
    int unsigned beat_cnt;
    int unsigned quiet_cnt;
    int unsigned send_gap;
    int unsigned send_calm;
    int unsigned stall_left;
    int unsigned stall_calm;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic note_mismatch(input string msg);
        if (mismatch_cnt < MAX_REPORTS) begin
            $display("ERROR @%0t beat %0d: %s", $time, beat_cnt, msg);
        end
        mismatch_cnt++;
    endtask

    // Mostly short pauses, now and then a long one.
    function automatic int unsigned draw_pause();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // One channel: centre plus gain (Q4.4) times the Laplacian (4*centre minus the 4 neighbours), cut at 0 and 255.
    function automatic logic [7:0] sharpen_chan(input logic [7:0] up, dn, lf, ctr, rt);
        int lap;
        int acc;
        lap = 4 * int'(ctr) - int'(up) - int'(dn) - int'(lf) - int'(rt);
        acc = 16 * int'(ctr) + int'(gain_reg) * lap;
        if (acc < 0) return 8'd0;
        if ((acc >>> 4) > 255) return 8'd255;
        return 8'(acc >>> 4);
    endfunction

    function automatic t_rgb sharpen_px(input t_rgb up, dn, lf, ctr, rt);
        t_rgb v;
        v.red   = sharpen_chan(up.red, dn.red, lf.red, ctr.red, rt.red);
        v.green = sharpen_chan(up.green, dn.green, lf.green, ctr.green, rt.green);
        v.blue  = sharpen_chan(up.blue, dn.blue, lf.blue, ctr.blue, rt.blue);
        return v;
    endfunction

    function automatic t_pix_out as_beat(input t_rgb v);
        t_pix_out b;
        b.red_out     = v.red;
        b.green_out   = v.green;
        b.blue_out    = v.blue;
        b.last_of_run = 1'b0;
        b.frame_done  = 1'b0;
        return b;
    endfunction

    // Advance the shadow sharpener by one input pixel and queue the beats it releases:
    // the pixel one row up and one column left, the right border of that row at the
    // last column, and on the last row the incoming pixel itself.
    task automatic predict_pixel(input t_pix_in px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned n;
        t_rgb        cur;
        t_rgb        up;
        t_rgb        mid;
        logic        last_col;
        logic        last_row;
        t_pix_out    run [3];
        w = (width_reg == '0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        h = (height_reg == '0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
        c = col_pos;
        r = row_pos;
        n = 0;
        cur.red   = px.red_in;
        cur.green = px.green_in;
        cur.blue  = px.blue_in;
        up  = upper_row[c];
        mid = middle_row[c];
        last_col = (c >= w - 1);
        last_row = (r >= h - 1);
        upper_row[c]  = mid;
        middle_row[c] = cur;
        if (r >= 1 && c >= 1) begin
            // sharpen only when the whole cross lies inside the frame
            if (r >= 2 && r + 1 <= h && c >= 2 && c + 1 <= w) begin
                run[n] = as_beat(sharpen_px(win[0], win[2], win[4], win[1], mid));
            end else begin
                run[n] = as_beat(win[1]);
            end
            n++;
        end
        if (r >= 1 && last_col) begin
            run[n] = as_beat(mid);
            n++;
        end
        if (last_row) begin
            run[n] = as_beat(cur);
            run[n].frame_done = last_col;
            n++;
        end
        if (n > 0) begin
            run[n - 1].last_of_run = 1'b1;
        end
        for (int unsigned k = 0; k < n; k++) begin
            expected_beats.push_back(run[k]);
        end
        win[3] = win[0];
        win[4] = win[1];
        win[5] = win[2];
        win[0] = up;
        win[1] = mid;
        win[2] = cur;
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    function automatic void queue_pixel(input t_pix_in px);
        stim_op_t op;
        op.kind    = OP_PIXEL;
        op.px      = px;
        op.reg_idx = CFG_WIDTH;
        op.value   = '0;
        pending_ops.push_back(op);
    endfunction

    function automatic void queue_write(input t_cfg_idx idx, input int unsigned value);
        stim_op_t op;
        op.kind    = OP_WRITE;
        op.px      = '0;
        op.reg_idx = idx;
        op.value   = CFG_DATA_W'(value);
        pending_ops.push_back(op);
    endfunction

    // Style 0: every channel at 0 or 255; style 1: small ripple around base; else uniform.
    function automatic t_pix_in draw_pixel(input int unsigned style, input int base);
        logic [23:0] v;
        int          lvl;
        for (int ch = 0; ch < 3; ch++) begin
            if (style == 0) begin
                lvl = $urandom_range(0, 1) ? 255 : 0;
            end else if (style == 1) begin
                lvl = base + int'($urandom_range(0, 6)) - 3;
                lvl = (lvl < 0) ? 0 : ((lvl > 255) ? 255 : lvl);
            end else begin
                lvl = $urandom_range(0, 255);
            end
            v[8*ch +: 8] = 8'(lvl);
        end
        return t_pix_in'(v);
    endfunction

    // Pixel driver: pull from the pending list, hold valid until the beat goes through,
    // insert random gaps, and only issue register writes once the sharpener is quiet.
    always @(posedge i_clk) begin : pixel_driver
        stim_op_t              op;
        logic                  nxt_valid;
        t_pix_in               nxt_px;
        logic                  nxt_we;
        logic [CFG_IDX_W-1:0]  nxt_idx;
        logic [CFG_DATA_W-1:0] nxt_data;
        nxt_valid = pix_ch.valid;
        nxt_px    = pix_ch.data;
        nxt_we    = 1'b0;
        nxt_idx   = i_cfg_idx;
        nxt_data  = i_cfg_data;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
            send_gap  = 0;
            send_calm = 0;
        end else begin
            if (pix_ch.valid && pix_ch.ready) begin
                predict_pixel(pix_ch.data);
                nxt_valid = 1'b0;
                // pick the gap before the next pixel; calm stretches skip gaps entirely
                if (send_calm > 0) begin
                    send_calm--;
                    send_gap = 0;
                end else begin
                    send_gap = draw_pause();
                    if ($urandom_range(0, 31) == 0) send_calm = $urandom_range(16, 64);
                end
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_ops.size() > 0) begin
                    // a pixel taken at this edge is still in flight: hold writes
                    if (pending_ops[0].kind == OP_PIXEL ||
                        (quiet_cnt >= QUIET_CYCLES && !pix_ch.valid)) begin
                        op = pending_ops.pop_front();
                        if (op.kind == OP_PIXEL) begin
                            nxt_valid = 1'b1;
                            nxt_px    = op.px;
                        end else begin
                            nxt_we   = 1'b1;
                            nxt_idx  = op.reg_idx;
                            nxt_data = op.value;
                            // mirror the write; a geometry change restarts the frame
                            case (op.reg_idx)
                                CFG_WIDTH: begin
                                    width_reg = op.value[WIDTH_W-1:0];
                                    col_pos   = 0;
                                    row_pos   = 0;
                                end
                                CFG_HEIGHT: begin
                                    height_reg = op.value[HEIGHT_W-1:0];
                                    col_pos    = 0;
                                    row_pos    = 0;
                                end
                                CFG_GAIN: begin
                                    gain_reg = op.value[GAIN_W-1:0];
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end
            end
        end
        pix_ch.valid <= nxt_valid;
        pix_ch.data  <= nxt_px;
        i_cfg_we     <= nxt_we;
        i_cfg_idx    <= nxt_idx;
        i_cfg_data   <= nxt_data;
    end

    // Result monitor: check every accepted beat against the oldest expectation,
    // stall ready at random, and track how long the sharpener has been idle.
    always @(posedge i_clk) begin : result_monitor
        t_pix_out got;
        t_pix_out want;
        logic     beat;
        beat = res_ch.valid && res_ch.ready;
        if (!i_rst_n) begin
            stall_left = 0;
            stall_calm = 0;
            res_ch.ready <= 1'b0;
            quiet_cnt    <= 0;
        end else begin
            if (beat) begin
                got = res_ch.data;
                if (expected_beats.size() == 0) begin
                    note_mismatch($sformatf("unexpected beat %06h", got[25:2]));
                end else begin
                    want = expected_beats.pop_front();
                    if (got.red_out !== want.red_out)
                        note_mismatch($sformatf("red got %0d want %0d",
                                                got.red_out, want.red_out));
                    if (got.green_out !== want.green_out)
                        note_mismatch($sformatf("green got %0d want %0d",
                                                got.green_out, want.green_out));
                    if (got.blue_out !== want.blue_out)
                        note_mismatch($sformatf("blue got %0d want %0d",
                                                got.blue_out, want.blue_out));
                    if (got.last_of_run !== want.last_of_run)
                        note_mismatch($sformatf("last_of_run got %0b want %0b",
                                                got.last_of_run, want.last_of_run));
                    if (got.frame_done !== want.frame_done)
                        note_mismatch($sformatf("frame_done got %0b want %0b",
                                                got.frame_done, want.frame_done));
                end
                beat_cnt++;
            end
            // drop ready after a beat now and then, and sometimes without one
            if (stall_left > 0) begin
                stall_left--;
            end else if (beat || $urandom_range(0, 15) == 0) begin
                if (stall_calm > 0) begin
                    stall_calm--;
                end else begin
                    stall_left = draw_pause();
                    if ($urandom_range(0, 31) == 0) stall_calm = $urandom_range(16, 64);
                end
            end
            res_ch.ready <= (stall_left == 0);
            quiet_cnt    <= (expected_beats.size() == 0 && !pix_ch.valid) ? quiet_cnt + 1 : 0;
        end
    end

    initial begin : stimulus
        t_pix_in     px;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned mode;
        int unsigned style;
        int unsigned sent;
        int          base;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_WIDTH;
        i_cfg_data   = '0;
        pix_ch.valid = 1'b0;
        pix_ch.data  = '0;
        res_ch.ready = 1'b0;
        width_reg    = WIDTH_RST;
        height_reg   = HEIGHT_RST;
        gain_reg     = GAIN_RST;
        col_pos      = 0;
        row_pos      = 0;
        mismatch_cnt = 0;
        beat_cnt     = 0;
        quiet_cnt    = 0;
        foreach (upper_row[k]) begin
            upper_row[k]  = '0;
            middle_row[k] = '0;
        end
        foreach (win[k]) win[k] = '0;

        // Directed: 3x3 frames at full gain, bright spot on black saturates high,
        // dark spot on white floors at zero; borders pass through.
        queue_write(CFG_WIDTH, 3);
        queue_write(CFG_HEIGHT, 3);
        queue_write(CFG_GAIN, 255);
        for (int k = 0; k < 9; k++) begin
            px = (k == 4) ? 24'hFFFFFF : 24'h000000;
            queue_pixel(px);
        end
        for (int k = 0; k < 9; k++) begin
            px = (k == 4) ? 24'h000000 : 24'hFFFFFF;
            queue_pixel(px);
        end
        // 2x2 frame at zero gain: everything is border, mixed channel extremes
        queue_write(CFG_GAIN, 0);
        queue_write(CFG_WIDTH, 2);
        queue_write(CFG_HEIGHT, 2);
        queue_pixel(24'hFF00FF);
        queue_pixel(24'h00FF00);
        queue_pixel(24'hFFFF00);
        queue_pixel(24'h0000FF);
        // zero width and height behave as one: every pixel is its own frame
        queue_write(CFG_WIDTH, 0);
        queue_write(CFG_HEIGHT, 0);
        queue_pixel(24'h123456);
        queue_pixel(24'hFEDCBA);
        queue_pixel(24'h80017F);

        // Random phases: mostly complete small frames, some partial ones, and gain
        // changes mid-frame without touching the geometry.
        w = 1;
        h = 1;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            mode = $urandom_range(0, 9);
            if (mode < 7) begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 6);
                queue_write(CFG_WIDTH, w);
                queue_write(CFG_HEIGHT, h);
            end
            if (mode >= 5) begin
                case ($urandom_range(0, 5))
                    0: queue_write(CFG_GAIN, 0);
                    1: queue_write(CFG_GAIN, 255);
                    2: queue_write(CFG_GAIN, 16);
                    default: queue_write(CFG_GAIN, $urandom_range(0, 255));
                endcase
            end
            if ($urandom_range(0, 3) != 0) n = w * h * $urandom_range(1, 2);
            else n = $urandom_range(1, w * h + 2);
            style = $urandom_range(0, 5);
            base  = $urandom_range(0, 255);
            for (int unsigned k = 0; k < n; k++) begin
                queue_pixel(draw_pixel(style, base));
            end
            sent += n;
        end

        // Widest line: data beyond the width field is dropped and 2047 clamps to the
        // maximum; a single-row frame, so every pixel returns at once.
        queue_write(CFG_WIDTH, 13'h1FFF);
        queue_write(CFG_HEIGHT, 1);
        for (int k = 0; k < WIDE_PIXELS; k++) begin
            queue_pixel(draw_pixel(2, 0));
        end
        // Tallest frames, only the top rows fed; the second one clamps 8191 down
        queue_write(CFG_GAIN, $urandom_range(8, 40));
        queue_write(CFG_WIDTH, 3);
        queue_write(CFG_HEIGHT, MAX_HEIGHT);
        for (int k = 0; k < 12; k++) begin
            queue_pixel(draw_pixel(2, 0));
        end
        queue_write(CFG_HEIGHT, 13'h1FFF);
        queue_write(CFG_WIDTH, 4);
        for (int k = 0; k < 14; k++) begin
            queue_pixel(draw_pixel(0, 0));
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for the list to empty and every expected beat to arrive, then idle
        while (pending_ops.size() != 0 || pix_ch.valid || expected_beats.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #25_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
